>>> design/wspm_pkg.sv
// Package for the wildcard star pattern matcher.
// Holds the operation codes, the special pattern bytes and the cell link types.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package wspm_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_APPEND  = 2'd1,
		OP_SUBJECT = 2'd2,
		OP_END     = 2'd3
	} op_t;

	localparam logic [7:0] DOT_BYTE  = 8'h2E;
	localparam logic [7:0] STAR_BYTE = 8'h2A;

	typedef struct packed {
		logic       clear;
		logic       append;
		logic       step;
		logic       rewind;
		logic [7:0] sym;
	} ctrl_t;

	typedef struct packed {
		logic origin;
		logic nxt;
		logic nxt_prev;
		logic cur;
		logic empty;
		logic empty_prev;
		logic hit;
	} link_t;

endpackage

>>> design/wspm_if.sv
// Handshake channels of the wildcard star pattern matcher.
// Command words carry operation and symbol; result words carry the match outcome.
// Depends on wspm_pkg.
`timescale 1ns / 1ps

interface wspm_cmd_if
	import wspm_pkg::*;
();
	logic       valid;
	logic       ready;
	op_t        operation;
	logic [7:0] symbol;

	modport source (output valid, output operation, output symbol, input ready);
	modport sink (input valid, input operation, input symbol, output ready);
endinterface

interface wspm_res_if;
	logic valid;
	logic ready;
	logic matched;
	logic pattern_overflow;

	modport source (output valid, output matched, output pattern_overflow, input ready);
	modport sink (input valid, input matched, input pattern_overflow, output ready);
endinterface

>>> design/wildcard_star_pattern_matcher.sv
// Top level of the wildcard star pattern matcher: command decode, row origin and result register.
// Depends on wspm_pkg, wspm_if and wspm_cell.
`timescale 1ns / 1ps

// Command words are decoded as they are accepted: a row of MAX_PATTERN cells, one per pattern
// position, updates the whole match row in the cycle a subject byte is accepted, and the
// ripple of star positions through that row sets the longest path. An end word loads the
// registered result word, which is valid in the next cycle; commands stall only while that
// result word is still held and the consumer is not ready. Clear, end and stored append words
// rewind the row; an append dropped on a full pattern leaves the row as it is.
// Pattern bytes beyond MAX_PATTERN are dropped and raise pattern_overflow until a clear.
module wildcard_star_pattern_matcher
	import wspm_pkg::*;
#(
	parameter int MAX_PATTERN = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	wspm_cmd_if.sink          cmd,
	wspm_res_if.source        res
);

	localparam int LW = $clog2(MAX_PATTERN + 1);

	logic [LW-1:0]        len_q;
	logic                 ovf_q;
	logic                 cur0_q;
	logic                 res_valid_q;
	logic                 res_matched_q;
	logic                 res_ovf_q;
	logic                 acc;
	logic                 full;
	ctrl_t                ctrl;
	link_t                links [MAX_PATTERN+1];
	logic [MAX_PATTERN:0] row;

	assign cmd.ready = !res_valid_q || res.ready;
	assign acc       = cmd.valid && cmd.ready;
	assign full      = (len_q == LW'(MAX_PATTERN));

	always_comb begin
		ctrl.clear  = 1'b0;
		ctrl.append = 1'b0;
		ctrl.step   = 1'b0;
		ctrl.rewind = 1'b0;
		ctrl.sym    = cmd.symbol;
		if (acc) begin
			unique case (cmd.operation)
				OP_CLEAR:   ctrl.clear  = 1'b1;
				OP_APPEND:  ctrl.append = !full;
				OP_SUBJECT: ctrl.step   = 1'b1;
				OP_END:     ctrl.rewind = 1'b1;
				default:    ctrl.rewind = 1'b0;
			endcase
		end
	end

	assign links[0].origin     = 1'b1;
	assign links[0].nxt        = 1'b0;
	assign links[0].nxt_prev   = 1'b0;
	assign links[0].cur        = cur0_q;
	assign links[0].empty      = 1'b1;
	assign links[0].empty_prev = 1'b0;
	assign links[0].hit        = 1'b0;
	assign row[0]              = cur0_q;

	for (genvar k = 1; k <= MAX_PATTERN; k++) begin : g_cell
		wspm_cell #(
			.LW  (LW),
			.IDX (k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.len    (len_q),
			.left   (links[k-1]),
			.right  (links[k])
		);
		assign row[k] = links[k].cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			ovf_q  <= 1'b0;
			cur0_q <= 1'b1;
		end else if (ctrl.clear) begin
			len_q  <= '0;
			ovf_q  <= 1'b0;
			cur0_q <= 1'b1;
		end else if (acc && (cmd.operation == OP_APPEND)) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				len_q  <= len_q + LW'(1);
				cur0_q <= 1'b1;
			end
		end else if (ctrl.step) begin
			cur0_q <= 1'b0;
		end else if (ctrl.rewind) begin
			cur0_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctrl.rewind) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rewind) begin
			res_matched_q <= !ovf_q && row[len_q];
			res_ovf_q     <= ovf_q;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.matched          = res_matched_q;
	assign res.pattern_overflow = res_ovf_q;

`ifndef ASSERT_OFF
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (cmd.operation == OP_CLEAR)) |=> (len_q == '0 && !ovf_q && cur0_q))
		else $error("clear word did not empty the pattern");

	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(acc && (cmd.operation == OP_END)))
		else $error("result word without an end word");

	a_no_match_on_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_matched_q && res_ovf_q))
		else $error("match reported while the pattern overflowed");

	a_subject_clears_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (cmd.operation == OP_SUBJECT)) |=> !cur0_q)
		else $error("row origin still set after a subject byte");

	a_overflow_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> $past(acc && (cmd.operation == OP_APPEND) && full))
		else $error("overflow raised without an append to a full pattern");
`endif

endmodule

>>> design/wspm_cell.sv
// One pattern position of the matcher: its pattern byte and its two row bits.
// Takes the link from its left neighbor and hands its own link to the right.
// Depends on wspm_pkg.
`timescale 1ns / 1ps

module wspm_cell
	import wspm_pkg::*;
#(
	parameter int LW  = 6,
	parameter int IDX = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ctrl_t         ctrl,
	input  logic [LW-1:0] len,
	input  link_t         left,
	output link_t         right
);

	logic [7:0] pat_q;
	logic       empty_q;
	logic       cur_q;
	logic       active;
	logic       load;
	logic       is_star;
	logic       hit;
	logic       nxt;
	logic       empty_new;

	assign active    = (len >= LW'(IDX));
	assign load      = ctrl.append && (len == LW'(IDX - 1));
	assign is_star   = (pat_q == STAR_BYTE);
	assign hit       = (pat_q == DOT_BYTE) || (!is_star && (pat_q == ctrl.sym));
	assign empty_new = (ctrl.sym == STAR_BYTE) && !left.origin
		&& (left.empty || left.empty_prev);

	always_comb begin
		if (!active) begin
			nxt = 1'b0;
		end else if (is_star) begin
			nxt = left.nxt || left.nxt_prev || (cur_q && left.hit);
		end else begin
			nxt = left.cur && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pat_q <= ctrl.sym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= 1'b0;
			cur_q   <= 1'b0;
		end else if (ctrl.clear) begin
			empty_q <= 1'b0;
			cur_q   <= 1'b0;
		end else if (load) begin
			empty_q <= empty_new;
			cur_q   <= empty_new;
		end else if (ctrl.append || ctrl.rewind) begin
			cur_q <= empty_q;
		end else if (ctrl.step) begin
			cur_q <= nxt;
		end
	end

	assign right.origin     = 1'b0;
	assign right.nxt        = nxt;
	assign right.nxt_prev   = left.nxt;
	assign right.cur        = cur_q;
	assign right.empty      = empty_q;
	assign right.empty_prev = left.empty;
	assign right.hit        = hit;

endmodule
